>>> hw/rtl/kft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flag table package
// Shared widths, command and status codes, sequencer states and the
// structs that pass between the table store, the scan unit and the top level.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int KEY_W_DEFAULT = 16;

  localparam int FUNC_W   = 3;
  localparam int KEY_IN_W = 16;
  localparam int FLAG_W   = 7;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  // Command codes.
  localparam logic [FUNC_W-1:0] FN_MASK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] RS_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] RS_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] RS_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] RS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] RS_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] RS_NOCHANGE = 3'd5;
  localparam logic [STATUS_W-1:0] RS_QUERY    = 3'd6;

  localparam logic [FLAG_W-1:0] FLAG_ALL    = 7'h7F;
  localparam logic [FLAG_W-1:0] INVITE_FLAG = 7'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } kft_state_t;

  typedef struct packed {
    logic start;
    logic cmp_en;
  } kft_scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic              free;
    logic [FLAG_W-1:0] hit_flags;
  } kft_scan_res_t;

  typedef struct packed {
    logic en;
    logic valid;
  } kft_wr_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/kft_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flag table channels
// Command and result channels, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface kft_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [kft_pkg::FUNC_W-1:0]   func;
  logic [kft_pkg::KEY_IN_W-1:0] key;
  logic [kft_pkg::FLAG_W-1:0]   flag_select;
  logic [kft_pkg::FLAG_W-1:0]   and_mask;
  logic [kft_pkg::FLAG_W-1:0]   xor_mask;

  modport source (output valid, func, key, flag_select, and_mask, xor_mask, input ready);
  modport sink (input valid, func, key, flag_select, and_mask, xor_mask, output ready);
endinterface

interface kft_res_if;
  logic                         valid;
  logic                         ready;
  logic [kft_pkg::STATUS_W-1:0] status;
  logic [kft_pkg::FLAG_W-1:0]   flags_now;
  logic                         flag_is_set;
  logic [kft_pkg::SLOT_W-1:0]   slot;
  logic                         send_invite;

  modport source (output valid, status, flags_now, flag_is_set, slot, send_invite,
                  input ready);
  modport sink (input valid, status, flags_now, flag_is_set, slot, send_invite,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/kft_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flag table store
// Key and flag memory with one write port and one registered read port,
// plus per-slot valid bits that reset clears at once.
// ----------------------------------------------------------------------------
module kft_store #(
  parameter int DEPTH = kft_pkg::DEPTH_DEFAULT,
  parameter int KEY_W = kft_pkg::KEY_W_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [IDX_W-1:0]          rd_addr,
  output logic                           rd_valid,
  output logic [KEY_W-1:0]               rd_key,
  output logic [kft_pkg::FLAG_W-1:0]     rd_flags,
  input  wire kft_pkg::kft_wr_ctl_t      wr,
  input  wire logic [IDX_W-1:0]          wr_addr,
  input  wire logic [KEY_W-1:0]          wr_key,
  input  wire logic [kft_pkg::FLAG_W-1:0] wr_flags
);

  localparam int WORD_W = KEY_W + kft_pkg::FLAG_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr_key, wr_flags};
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_addr] <= wr.valid;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_key   = rd_word[WORD_W-1:kft_pkg::FLAG_W];
  assign rd_flags = rd_word[kft_pkg::FLAG_W-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/kft_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flag table scan unit
// Key comparator shared across all slots, one slot per cycle. Keeps the
// lowest matching valid slot and the lowest free slot seen so far.
// ----------------------------------------------------------------------------
module kft_scan #(
  parameter int DEPTH = kft_pkg::DEPTH_DEFAULT,
  parameter int KEY_W = kft_pkg::KEY_W_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire kft_pkg::kft_scan_ctl_t     ctl,
  input  wire logic [IDX_W-1:0]           cmp_idx,
  input  wire logic                       rd_valid,
  input  wire logic [KEY_W-1:0]           rd_key,
  input  wire logic [kft_pkg::FLAG_W-1:0] rd_flags,
  input  wire logic [KEY_W-1:0]           key,
  output kft_pkg::kft_scan_res_t          res,
  output logic [IDX_W-1:0]                hit_idx,
  output logic [IDX_W-1:0]                free_idx
);

  logic is_match;
  logic take_hit;
  logic take_free;

  assign is_match  = rd_valid && (rd_key == key);
  assign take_hit  = ctl.cmp_en && !res.hit && is_match;
  assign take_free = ctl.cmp_en && !res.free && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      res.hit  <= 1'b0;
      res.free <= 1'b0;
    end else begin
      if (take_hit) begin
        res.hit       <= 1'b1;
        res.hit_flags <= rd_flags;
      end
      if (take_free) begin
        res.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx <= cmp_idx;
    end
    if (take_free) begin
      free_idx <= cmp_idx;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/keyed_flag_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flag table
// Associative table of keys with seven flag bits each, updated by mask,
// set, clear and toggle commands and read by queries.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  cmd      in         func, key, flag_select, and_mask, xor_mask
//  res      out        status, flags_now, flag_is_set, slot, send_invite
//
// Each item passes from acceptance through the scan state, one slot per cycle
// through the store's read port into the shared key comparator, a drain state
// for the last compare, and an apply state that waits for a free result register.
// cmd.ready is high only while the sequencer is idle; one item is in work.
// The result register lets a new item be accepted while a result waits.
// Reset clears all valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_flag_table #(
  parameter int TABLE_DEPTH = kft_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = kft_pkg::KEY_W_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  kft_cmd_if.sink   cmd,
  kft_res_if.source res
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int FW    = kft_pkg::FLAG_W;

  kft_pkg::kft_state_t state, state_next;

  logic [CNT_W-1:0] ptr;
  logic             accept;
  logic             load;
  logic             scan_last;

  // Latched command.
  logic [kft_pkg::FUNC_W-1:0] c_func;
  logic [KEY_WIDTH-1:0]       c_key;
  logic [FW-1:0]              c_sel;
  logic [FW-1:0]              c_and;
  logic [FW-1:0]              c_xor;

  // Store and scan connections.
  logic                   cmp_en;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   rd_valid;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [FW-1:0]          rd_flags;
  kft_pkg::kft_scan_ctl_t scan_ctl;
  kft_pkg::kft_scan_res_t scan_res;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  kft_pkg::kft_wr_ctl_t   wr;
  logic [IDX_W-1:0]       wr_addr;
  logic [FW-1:0]          wr_flags;

  // Decision for the item.
  logic [kft_pkg::STATUS_W-1:0] d_status;
  logic [FW-1:0]                d_now;
  logic                         d_isset;
  logic [IDX_W-1:0]             d_slot;
  logic                         d_invite;
  logic                         d_we;
  logic                         d_keep;
  logic [IDX_W-1:0]             d_addr;
  logic [FW-1:0]                new_flags;
  logic                         do_set;

  // Result register.
  logic                         res_valid;
  logic [kft_pkg::STATUS_W-1:0] res_status;
  logic [FW-1:0]                res_flags;
  logic                         res_isset;
  logic [kft_pkg::SLOT_W-1:0]   res_slot;
  logic                         res_invite;

  assign accept    = cmd.valid && cmd.ready;
  assign scan_last = (ptr == CNT_W'(TABLE_DEPTH - 1));
  assign load      = (state == kft_pkg::ST_APPLY) && (!res_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      kft_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = kft_pkg::ST_SCAN;
      end
      kft_pkg::ST_SCAN: begin
        if (scan_last) state_next = kft_pkg::ST_DRAIN;
      end
      kft_pkg::ST_DRAIN: begin
        state_next = kft_pkg::ST_APPLY;
      end
      kft_pkg::ST_APPLY: begin
        if (load) state_next = kft_pkg::ST_IDLE;
      end
      default: state_next = kft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready       = (state == kft_pkg::ST_IDLE);
    scan_ctl.start  = accept;
    scan_ctl.cmp_en = cmp_en;
    wr.en           = load && d_we;
    wr.valid        = d_keep;
    wr_addr         = d_addr;
    wr_flags        = d_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kft_pkg::ST_IDLE;
      cmp_en <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == kft_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ptr    <= '0;
      c_func <= cmd.func;
      c_key  <= KEY_WIDTH'(cmd.key);
      c_sel  <= cmd.flag_select;
      c_and  <= cmd.and_mask;
      c_xor  <= cmd.xor_mask;
    end else if (state == kft_pkg::ST_SCAN) begin
      ptr <= ptr + CNT_W'(1);
    end
    cmp_idx <= ptr[IDX_W-1:0];
  end

  kft_store #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (ptr[IDX_W-1:0]),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_flags (rd_flags),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_key   (c_key),
    .wr_flags (wr_flags)
  );

  kft_scan #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .cmp_idx  (cmp_idx),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_flags (rd_flags),
    .key      (c_key),
    .res      (scan_res),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  // Outcome of the command from the scan result.
  always_comb begin
    d_status  = kft_pkg::RS_NOCHANGE;
    d_now     = '0;
    d_isset   = 1'b0;
    d_slot    = '0;
    d_invite  = 1'b0;
    d_we      = 1'b0;
    d_keep    = 1'b1;
    d_addr    = hit_idx;
    new_flags = '0;
    do_set    = 1'b0;
    unique case (c_func)
      kft_pkg::FN_MASK: begin
        if (scan_res.hit) begin
          d_slot = hit_idx;
          d_now  = scan_res.hit_flags;
        end
        new_flags = (scan_res.hit_flags & c_and) ^ c_xor;
        if (c_and == kft_pkg::FLAG_ALL && c_xor == '0) begin
          d_status = kft_pkg::RS_NOCHANGE;
        end else if (scan_res.hit) begin
          d_now  = new_flags;
          d_we   = 1'b1;
          d_keep = (new_flags != '0);
          d_status = (new_flags == '0) ? kft_pkg::RS_REMOVED : kft_pkg::RS_UPDATED;
        end else if (c_xor == '0) begin
          d_status = kft_pkg::RS_NOCHANGE;
        end else if (!scan_res.free) begin
          d_status = kft_pkg::RS_FULL;
        end else begin
          d_status = kft_pkg::RS_ADDED;
          d_now    = c_xor;
          d_slot   = free_idx;
          d_addr   = free_idx;
          d_we     = 1'b1;
        end
      end
      kft_pkg::FN_QUERY, kft_pkg::FN_SET, kft_pkg::FN_CLEAR, kft_pkg::FN_TOGGLE: begin
        if (!scan_res.hit) begin
          if (c_func == kft_pkg::FN_QUERY || c_func == kft_pkg::FN_CLEAR) begin
            d_status = kft_pkg::RS_NOTFOUND;
          end else if (!scan_res.free) begin
            d_status = kft_pkg::RS_FULL;
          end else begin
            // A new entry stays valid even when the selected flags are zero.
            d_status = kft_pkg::RS_ADDED;
            d_now    = c_sel;
            d_slot   = free_idx;
            d_addr   = free_idx;
            d_we     = 1'b1;
            d_invite = (c_sel == kft_pkg::INVITE_FLAG);
          end
        end else begin
          d_slot = hit_idx;
          if (c_func == kft_pkg::FN_QUERY) begin
            d_status = kft_pkg::RS_QUERY;
            d_now    = scan_res.hit_flags;
            d_isset  = ((scan_res.hit_flags & c_sel) != '0);
          end else begin
            do_set = (c_func == kft_pkg::FN_SET) ||
                     (c_func == kft_pkg::FN_TOGGLE && (scan_res.hit_flags & c_sel) == '0);
            d_we = 1'b1;
            if (do_set) begin
              d_now    = scan_res.hit_flags | c_sel;
              d_status = kft_pkg::RS_UPDATED;
              d_invite = (c_sel == kft_pkg::INVITE_FLAG);
            end else begin
              new_flags = scan_res.hit_flags & ~c_sel;
              d_now     = new_flags;
              d_keep    = (new_flags != '0);
              d_status  = (new_flags == '0) ? kft_pkg::RS_REMOVED : kft_pkg::RS_UPDATED;
            end
          end
        end
      end
      default: begin
        d_status = kft_pkg::RS_NOCHANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= d_status;
      res_flags  <= d_now;
      res_isset  <= d_isset;
      res_slot   <= kft_pkg::SLOT_W'(d_slot);
      res_invite <= d_invite;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.flags_now   = res_flags;
  assign res.flag_is_set = res_isset;
  assign res.slot        = res_slot;
  assign res.send_invite = res_invite;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == kft_pkg::ST_SCAN))
    else $error("accepted item did not start a scan");

  a_write_on_load: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == kft_pkg::ST_APPLY && (!res_valid || res.ready)))
    else $error("table written outside result load");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == kft_pkg::RS_REMOVED) |-> (res.flags_now == '0))
    else $error("removed entry reports nonzero flags");

  a_isset_query: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.flag_is_set) |-> (res.status == kft_pkg::RS_QUERY))
    else $error("flag answer outside a query");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == kft_pkg::ST_SCAN) |-> (ptr < CNT_W'(TABLE_DEPTH)))
    else $error("scan pointer beyond table");

endmodule
`default_nettype wire
